/* rtl/hex_literal_to_decimal_filter_defines.svh */
// Assertion macros used by the top module to check itself.
`ifndef HEX_LITERAL_TO_DECIMAL_FILTER_DEFINES_SVH
`define HEX_LITERAL_TO_DECIMAL_FILTER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HLTD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HLTD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/hltd_pkg.sv */
package hltd_pkg;

  localparam int ACC_BITS_DEF = 32;
  localparam int FIFO_DEPTH   = 4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_MINUS = 8'h2d;

  // Prefix bytes that a command emits before anything else.
  typedef enum logic [1:0] {
    PRE_NONE   = 2'd0,
    PRE_ZERO   = 2'd1,
    PRE_ZERO_X = 2'd2
  } pre_t;

  // Control half of one queued command: prefix, then decimal, then the byte.
  typedef struct packed {
    pre_t       pre;
    logic       has_num;
    logic       has_char;
    logic [7:0] char_val;
  } cmd_ctrl_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } q_stat_t;

  // Bit 4 marks a hex digit, bits 3:0 hold its value.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = '0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LOW_A && c <= CH_LOW_F)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // Decimal digits needed for an unsigned value of the given width.
  function automatic int dec_digits(input int bits);
    return (bits * 30103) / 100000 + 1;
  endfunction

endpackage

/* rtl/hltd_front.sv */
module hltd_front #(
  parameter int ACC_BITS = hltd_pkg::ACC_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [7:0]            in_tdata,
  input  logic                  in_tuser,
  input  hltd_pkg::q_stat_t     q_stat,
  output logic                  push,
  output hltd_pkg::cmd_ctrl_t   push_ctrl,
  output logic [ACC_BITS-1:0]   push_value
);

  typedef enum logic [3:0] {
    SC_IDLE   = 4'b0001,
    SC_ZERO   = 4'b0010,
    SC_PREFIX = 4'b0100,
    SC_DIGITS = 4'b1000
  } scan_t;

  scan_t               mode_r, mode_nxt;
  logic [ACC_BITS-1:0] acc_r, acc_nxt;
  logic                accept;
  logic [4:0]          hex;

  assign in_tready = !q_stat.full;
  assign accept    = in_tvalid && !q_stat.full;
  assign hex       = hltd_pkg::hex_digit(in_tdata);

  always_comb begin
    mode_nxt            = mode_r;
    acc_nxt             = acc_r;
    push                = 1'b0;
    push_ctrl.pre       = hltd_pkg::PRE_NONE;
    push_ctrl.has_num   = 1'b0;
    push_ctrl.has_char  = 1'b0;
    push_ctrl.char_val  = in_tdata;
    push_value          = acc_r;
    if (accept) begin
      if (in_tuser) begin
        case (mode_r)
          SC_ZERO: begin
            push          = 1'b1;
            push_ctrl.pre = hltd_pkg::PRE_ZERO;
          end
          SC_PREFIX: begin
            push          = 1'b1;
            push_ctrl.pre = hltd_pkg::PRE_ZERO_X;
          end
          SC_DIGITS: begin
            push              = 1'b1;
            push_ctrl.has_num = 1'b1;
          end
          default: ;
        endcase
        mode_nxt = SC_IDLE;
        acc_nxt  = '0;
      end else begin
        case (mode_r)
          SC_IDLE: begin
            if (in_tdata == hltd_pkg::CH_ZERO) begin
              mode_nxt = SC_ZERO;
            end else begin
              push               = 1'b1;
              push_ctrl.has_char = 1'b1;
            end
          end
          SC_ZERO: begin
            if (in_tdata == hltd_pkg::CH_X) begin
              mode_nxt = SC_PREFIX;
            end else begin
              push               = 1'b1;
              push_ctrl.pre      = hltd_pkg::PRE_ZERO;
              push_ctrl.has_char = 1'b1;
              mode_nxt           = SC_IDLE;
            end
          end
          SC_PREFIX: begin
            if (hex[4]) begin
              acc_nxt  = {{(ACC_BITS-4){1'b0}}, hex[3:0]};
              mode_nxt = SC_DIGITS;
            end else begin
              push               = 1'b1;
              push_ctrl.pre      = hltd_pkg::PRE_ZERO_X;
              push_ctrl.has_char = 1'b1;
              mode_nxt           = SC_IDLE;
            end
          end
          SC_DIGITS: begin
            if (hex[4]) begin
              acc_nxt = {acc_r[ACC_BITS-5:0], hex[3:0]};
            end else begin
              push               = 1'b1;
              push_ctrl.has_num  = 1'b1;
              push_ctrl.has_char = 1'b1;
              acc_nxt            = '0;
              mode_nxt           = SC_IDLE;
            end
          end
          default: begin
            mode_nxt = SC_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= SC_IDLE;
      acc_r  <= '0;
    end else begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
    end
  end

endmodule

/* rtl/hltd_fifo.sv */
module hltd_fifo #(
  parameter int DATA_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] wr_data,
  input  logic              pop,
  output logic [DATA_W-1:0] rd_data,
  output hltd_pkg::q_stat_t q_stat
);

  localparam int DEPTH = hltd_pkg::FIFO_DEPTH;
  localparam int AW    = $clog2(DEPTH);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [AW:0]       cnt_r;

  assign rd_data          = mem_r[rd_ptr_r];
  assign q_stat.not_empty = (cnt_r != '0);
  assign q_stat.full      = (cnt_r == (AW+1)'(DEPTH));

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + AW'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + AW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + (AW+1)'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - (AW+1)'(1);
      end
    end
  end

endmodule

/* rtl/hltd_back.sv */
module hltd_back #(
  parameter int ACC_BITS = hltd_pkg::ACC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  hltd_pkg::cmd_ctrl_t q_ctrl,
  input  logic [ACC_BITS-1:0] q_value,
  output logic                pop,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [7:0]          out_tdata,
  output logic                out_tlast
);

  localparam int NDIG  = hltd_pkg::dec_digits(ACC_BITS);
  localparam int BCD_W = NDIG * 4;
  localparam int CNT_W = $clog2(ACC_BITS);
  localparam int DIG_W = $clog2(NDIG);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRE  = 6'b000010,
    ST_SIGN = 6'b000100,
    ST_CONV = 6'b001000,
    ST_DIG  = 6'b010000,
    ST_CHAR = 6'b100000
  } st_t;

  st_t                 st_r, st_nxt;
  hltd_pkg::pre_t      pre_r, pre_nxt;
  logic                pre_idx_r, pre_idx_nxt;
  logic                has_num_r, has_num_nxt;
  logic                has_char_r, has_char_nxt;
  logic                neg_r, neg_nxt;
  logic [7:0]          char_r, char_nxt;
  logic [ACC_BITS-1:0] bin_r, bin_nxt;
  logic [BCD_W-1:0]    bcd_r, bcd_nxt, bcd_adj;
  logic [CNT_W-1:0]    bit_cnt_r, bit_cnt_nxt;
  logic [DIG_W-1:0]    dig_cnt_r, dig_cnt_nxt;
  logic                started_r, started_nxt;
  logic                out_tvalid_r, out_tlast_r;
  logic [7:0]          out_tdata_r;

  logic                out_free, emit, emit_last, load, finish, pre_last, q_neg;
  logic [7:0]          emit_byte;
  logic [3:0]          top_dig;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tlast  = out_tlast_r;
  assign out_free   = !out_tvalid_r || out_tready;
  assign top_dig    = bcd_r[BCD_W-1 -: 4];
  assign pre_last   = (pre_r == hltd_pkg::PRE_ZERO) || pre_idx_r;
  assign q_neg      = q_ctrl.has_num && q_value[ACC_BITS-1];

  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      bcd_adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                    : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    st_nxt       = st_r;
    pre_nxt      = pre_r;
    pre_idx_nxt  = pre_idx_r;
    has_num_nxt  = has_num_r;
    has_char_nxt = has_char_r;
    neg_nxt      = neg_r;
    char_nxt     = char_r;
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    dig_cnt_nxt  = dig_cnt_r;
    started_nxt  = started_r;
    emit         = 1'b0;
    emit_last    = 1'b0;
    emit_byte    = char_r;
    load         = 1'b0;
    finish       = 1'b0;
    pop          = 1'b0;

    case (st_r)
      ST_IDLE: begin
        load = q_valid;
      end
      ST_PRE: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = pre_idx_r ? hltd_pkg::CH_X : hltd_pkg::CH_ZERO;
          emit_last = pre_last && !has_num_r && !has_char_r;
          if (!pre_last) begin
            pre_idx_nxt = 1'b1;
          end else if (has_num_r) begin
            st_nxt = neg_r ? ST_SIGN : ST_CONV;
          end else if (has_char_r) begin
            st_nxt = ST_CHAR;
          end else begin
            finish = 1'b1;
          end
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = hltd_pkg::CH_MINUS;
          st_nxt    = ST_CONV;
        end
      end
      ST_CONV: begin
        bcd_nxt = {bcd_adj[BCD_W-2:0], bin_r[ACC_BITS-1]};
        bin_nxt = {bin_r[ACC_BITS-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          st_nxt      = ST_DIG;
          dig_cnt_nxt = DIG_W'(NDIG - 1);
          started_nxt = 1'b0;
        end else begin
          bit_cnt_nxt = bit_cnt_r - CNT_W'(1);
        end
      end
      ST_DIG: begin
        if (!started_r && top_dig == 4'd0 && dig_cnt_r != '0) begin
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          dig_cnt_nxt = dig_cnt_r - DIG_W'(1);
        end else if (out_free) begin
          emit        = 1'b1;
          emit_byte   = hltd_pkg::CH_ZERO + {4'd0, top_dig};
          emit_last   = (dig_cnt_r == '0) && !has_char_r;
          started_nxt = 1'b1;
          bcd_nxt     = {bcd_r[BCD_W-5:0], 4'd0};
          if (dig_cnt_r == '0) begin
            if (has_char_r) begin
              st_nxt = ST_CHAR;
            end else begin
              finish = 1'b1;
            end
          end else begin
            dig_cnt_nxt = dig_cnt_r - DIG_W'(1);
          end
        end
      end
      ST_CHAR: begin
        if (out_free) begin
          emit      = 1'b1;
          emit_byte = char_r;
          emit_last = 1'b1;
          finish    = 1'b1;
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase

    if (finish) begin
      st_nxt = ST_IDLE;
      load   = q_valid;
    end

    if (load) begin
      pop          = 1'b1;
      pre_nxt      = q_ctrl.pre;
      pre_idx_nxt  = 1'b0;
      has_num_nxt  = q_ctrl.has_num;
      has_char_nxt = q_ctrl.has_char;
      char_nxt     = q_ctrl.char_val;
      neg_nxt      = q_neg;
      bin_nxt      = q_neg ? (~q_value + ACC_BITS'(1)) : q_value;
      bcd_nxt      = '0;
      bit_cnt_nxt  = CNT_W'(ACC_BITS - 1);
      if (q_ctrl.pre != hltd_pkg::PRE_NONE) begin
        st_nxt = ST_PRE;
      end else if (q_ctrl.has_num) begin
        st_nxt = q_neg ? ST_SIGN : ST_CONV;
      end else begin
        st_nxt = ST_CHAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= ST_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    pre_r      <= pre_nxt;
    pre_idx_r  <= pre_idx_nxt;
    has_num_r  <= has_num_nxt;
    has_char_r <= has_char_nxt;
    neg_r      <= neg_nxt;
    char_r     <= char_nxt;
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    dig_cnt_r  <= dig_cnt_nxt;
    started_r  <= started_nxt;
    if (emit) begin
      out_tdata_r <= emit_byte;
      out_tlast_r <= emit_last;
    end
  end

endmodule

/* rtl/hex_literal_to_decimal_filter.sv */
// Text filter that passes bytes through and rewrites each 0x hex literal as signed decimal
// text. A scanner takes one item per cycle while the queue is not full and queues a short
// command whenever bytes are due; an emitter drains the four-entry queue through a
// registered output. Ordinary bytes flow at one per cycle while the output is ready.
// A '0', an 'x' after it and hex digits give no output when they arrive. A finished number
// gets a minus sign when negative, ACC_BITS-bit shift-and-add-3 conversion, a digit per
// position (leading zeros skipped at one per cycle, 10 positions for 32 bits) and any
// ending byte; the scanner accepts until the queue fills. tlast marks the last byte
// caused by an input item; an end item (tuser high) flushes a pending prefix or number.
`include "hex_literal_to_decimal_filter_defines.svh"

module hex_literal_to_decimal_filter #(
  parameter int ACC_BITS = hltd_pkg::ACC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // char_in
  input  logic       in_tuser,   // kind
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // char_out
  output logic       out_tlast
);

  localparam int CTRL_W = $bits(hltd_pkg::cmd_ctrl_t);
  localparam int DATA_W = ACC_BITS + CTRL_W;

  hltd_pkg::q_stat_t   q_stat;
  hltd_pkg::cmd_ctrl_t push_ctrl, rd_ctrl;
  logic [ACC_BITS-1:0] push_value, rd_value;
  logic [DATA_W-1:0]   wr_data, rd_data;
  logic                q_push, q_pop;

  assign wr_data  = {push_value, push_ctrl};
  assign rd_ctrl  = hltd_pkg::cmd_ctrl_t'(rd_data[CTRL_W-1:0]);
  assign rd_value = rd_data[DATA_W-1:CTRL_W];

  hltd_front #(.ACC_BITS(ACC_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .q_stat     (q_stat),
    .push       (q_push),
    .push_ctrl  (push_ctrl),
    .push_value (push_value)
  );

  hltd_fifo #(.DATA_W(DATA_W)) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_data (wr_data),
    .pop     (q_pop),
    .rd_data (rd_data),
    .q_stat  (q_stat)
  );

  hltd_back #(.ACC_BITS(ACC_BITS)) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_stat.not_empty),
    .q_ctrl     (rd_ctrl),
    .q_value    (rd_value),
    .pop        (q_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  `HLTD_ASSERT_NOW(a_push_not_full, q_push, !q_stat.full, "Command pushed into a full queue.")
  `HLTD_ASSERT_NOW(a_pop_not_empty, q_pop, q_stat.not_empty, "Command popped from an empty queue.")
  `HLTD_ASSERT_NEXT(a_full_holds_off, q_stat.full && !q_pop, !in_tready, "Input taken while the queue stays full.")

endmodule

/* test/hex_literal_to_decimal_filter_tb.sv */
`timescale 1ns / 1ps

module hex_literal_to_decimal_filter_tb;

  localparam int ACC_W = hltd_pkg::ACC_BITS_DEF;
  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;
  localparam logic [7:0] CH_UP_X = 8'h58;
  localparam logic [7:0] CH_COMMA = 8'h2c;
  localparam logic [7:0] CH_LOW_Q = 8'h71;
  localparam int RANDOM_ITEMS = 330;

  typedef enum logic [1:0] {
    SCAN_IDLE   = 2'd0,
    SCAN_ZERO   = 2'd1,
    SCAN_PREFIX = 2'd2,
    SCAN_DIGITS = 2'd3
  } scan_mode_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } text_byte_t;

  class filter_scoreboard;
    scan_mode_t       mode;
    logic [ACC_W-1:0] acc;
    logic [7:0]       run[$];
    text_byte_t       due[$];
    int               errors;

    function new();
      mode = SCAN_IDLE;
      acc = '0;
      errors = 0;
    endfunction

    function automatic logic digit_of(input logic [7:0] c, output logic [3:0] v);
      v = '0;
      if (c >= hltd_pkg::CH_ZERO && c <= hltd_pkg::CH_NINE) begin
        v = 4'(c - hltd_pkg::CH_ZERO);
        return 1'b1;
      end
      if (c >= hltd_pkg::CH_UP_A && c <= hltd_pkg::CH_UP_F) begin
        v = 4'(c - hltd_pkg::CH_UP_A + 8'd10);
        return 1'b1;
      end
      if (c >= hltd_pkg::CH_LOW_A && c <= hltd_pkg::CH_LOW_F) begin
        v = 4'(c - hltd_pkg::CH_LOW_A + 8'd10);
        return 1'b1;
      end
      return 1'b0;
    endfunction

    function void put_decimal();
      logic [ACC_W-1:0] mag;
      logic [7:0] digs[$];
      if (acc[ACC_W-1]) begin
        run.push_back(hltd_pkg::CH_MINUS);
        mag = -acc;
      end else begin
        mag = acc;
      end
      do begin
        digs.push_front(8'(mag % 10) + hltd_pkg::CH_ZERO);
        mag = mag / 10;
      end while (mag != 0);
      foreach (digs[i]) run.push_back(digs[i]);
    endfunction

    function void note_input(input logic kind, input logic [7:0] c);
      logic [3:0] v;
      logic is_hex;
      text_byte_t b;
      run.delete();
      is_hex = digit_of(c, v);
      if (kind == KIND_END) begin
        case (mode)
          SCAN_ZERO: run.push_back(hltd_pkg::CH_ZERO);
          SCAN_PREFIX: begin
            run.push_back(hltd_pkg::CH_ZERO);
            run.push_back(hltd_pkg::CH_X);
          end
          SCAN_DIGITS: put_decimal();
          default: ;
        endcase
        mode = SCAN_IDLE;
        acc = '0;
      end else begin
        case (mode)
          SCAN_IDLE: begin
            if (c == hltd_pkg::CH_ZERO) mode = SCAN_ZERO;
            else run.push_back(c);
          end
          SCAN_ZERO: begin
            if (c == hltd_pkg::CH_X) begin
              mode = SCAN_PREFIX;
            end else begin
              run.push_back(hltd_pkg::CH_ZERO);
              run.push_back(c);
              mode = SCAN_IDLE;
            end
          end
          SCAN_PREFIX: begin
            if (is_hex) begin
              acc = ACC_W'(v);
              mode = SCAN_DIGITS;
            end else begin
              run.push_back(hltd_pkg::CH_ZERO);
              run.push_back(hltd_pkg::CH_X);
              run.push_back(c);
              mode = SCAN_IDLE;
            end
          end
          default: begin
            if (is_hex) begin
              acc = (acc << 4) | ACC_W'(v);
            end else begin
              put_decimal();
              run.push_back(c);
              acc = '0;
              mode = SCAN_IDLE;
            end
          end
        endcase
      end
      foreach (run[i]) begin
        b.ch = run[i];
        b.last = (i == run.size() - 1);
        due.push_back(b);
      end
    endfunction

    function void check_result(input logic [7:0] c, input logic last);
      text_byte_t e;
      if (due.size() == 0) begin
        $error("unexpected item: char_out %h, last_of_run %b", c, last);
        errors++;
        return;
      end
      e = due.pop_front();
      if (c !== e.ch) begin
        $error("char_out: expected %h, got %h", e.ch, c);
        errors++;
      end
      if (last !== e.last) begin
        $error("last_of_run: expected %b, got %b", e.last, last);
        errors++;
      end
    endfunction

    function int pending();
      return due.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = '0;
  logic       in_tuser = 1'b0;
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;
  logic       out_tlast;

  filter_scoreboard board = new();
  bit quiet = 1'b0;
  int stall_left = 0;
  int sent = 0;

  hex_literal_to_decimal_filter uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .in_tdata(in_tdata),
    .in_tuser(in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      stall_left = pick_gap();
    end
    out_tready <= (stall_left == 0);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tlast);
  end

  task automatic send_item(input logic kind, input logic [7:0] c);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= c;
    do @(posedge clk); while (!in_tready);
    board.note_input(kind, c);
    sent++;
  endtask

  task automatic send_text(input string s);
    foreach (s[i]) send_item(KIND_DATA, s[i]);
  endtask

  function automatic logic [7:0] random_digit();
    logic [3:0] v;
    v = 4'($urandom_range(0, 15));
    if (v < 10) return hltd_pkg::CH_ZERO + 8'(v);
    return ($urandom_range(0, 1) ? hltd_pkg::CH_UP_A : hltd_pkg::CH_LOW_A) + 8'(v) - 8'd10;
  endfunction

  function automatic logic [7:0] random_non_hex();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while ((c >= hltd_pkg::CH_ZERO && c <= hltd_pkg::CH_NINE) ||
           (c >= hltd_pkg::CH_UP_A && c <= hltd_pkg::CH_UP_F) ||
           (c >= hltd_pkg::CH_LOW_A && c <= hltd_pkg::CH_LOW_F));
    return c;
  endfunction

  task automatic send_literal();
    int len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 20) : $urandom_range(1, 8);
    send_item(KIND_DATA, hltd_pkg::CH_ZERO);
    send_item(KIND_DATA, hltd_pkg::CH_X);
    repeat (len) send_item(KIND_DATA, random_digit());
    if ($urandom_range(0, 4) == 0) send_item(KIND_END, 8'($urandom_range(0, 255)));
    else send_item(KIND_DATA, random_non_hex());
  endtask

  task automatic send_broken();
    case ($urandom_range(0, 3))
      0: begin
        send_item(KIND_DATA, hltd_pkg::CH_ZERO);
        send_item(KIND_DATA, 8'($urandom_range(0, 255)));
      end
      1: begin
        send_item(KIND_DATA, hltd_pkg::CH_ZERO);
        send_item(KIND_DATA, hltd_pkg::CH_X);
        send_item(KIND_DATA, random_non_hex());
      end
      2: begin
        send_item(KIND_DATA, hltd_pkg::CH_ZERO);
        send_item(KIND_DATA, CH_UP_X);
      end
      default: send_item(KIND_END, 8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int start;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_text("0x80000000");
    send_item(KIND_END, 8'hff);
    send_item(KIND_DATA, hltd_pkg::CH_ZERO);
    send_item(KIND_DATA, CH_LOW_Q);
    send_item(KIND_DATA, hltd_pkg::CH_ZERO);
    send_item(KIND_DATA, CH_UP_X);
    send_text("0xg");
    send_item(KIND_DATA, hltd_pkg::CH_ZERO);
    send_item(KIND_END, 8'h00);
    send_item(KIND_DATA, hltd_pkg::CH_ZERO);
    send_item(KIND_DATA, hltd_pkg::CH_X);
    send_item(KIND_END, 8'h00);
    send_item(KIND_END, 8'h00);
    send_text("00x1");
    send_item(KIND_DATA, CH_COMMA);

    start = sent;
    while (sent - start < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) quiet = !quiet;
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: send_literal();
        5, 6, 7: repeat ($urandom_range(1, 4)) send_item(KIND_DATA, 8'($urandom_range(0, 255)));
        default: send_broken();
      endcase
    end
    send_item(KIND_END, 8'h00);
    in_tvalid <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #40_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
